[hw/rtl/tafbl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tafbl_pkg
// Shared types, widths and helpers for the triangle area share pipeline.
// ----------------------------------------------------------------------------
package tafbl_pkg;

  localparam int unsigned CoordWidth = 32;
  localparam int unsigned FracBits   = 16;
  localparam int unsigned ProdWidth  = 2 * CoordWidth;

  typedef logic signed [CoordWidth-1:0] coord_t;

  typedef struct packed {
    coord_t vertex_a_x;
    coord_t vertex_a_y;
    coord_t vertex_b_x;
    coord_t vertex_b_y;
    coord_t vertex_c_x;
    coord_t vertex_c_y;
  } tafbl_in_t;

  typedef struct packed {
    logic [FracBits:0] covered_fraction;
    logic              bad_triangle;
  } tafbl_out_t;

  typedef enum logic [1:0] {
    KIND_EMPTY,
    KIND_FULL,
    KIND_CUT,
    KIND_BAD
  } tafbl_kind_e;

  typedef struct packed {
    tafbl_kind_e            kind;
    logic [ProdWidth-1:0]   num;
    logic [ProdWidth-1:0]   den;
  } tafbl_div_t;

  function automatic logic [CoordWidth-1:0] diff_mag(coord_t a, coord_t b);
    logic signed [CoordWidth:0] d;
    d = $signed({a[CoordWidth-1], a}) - $signed({b[CoordWidth-1], b});
    return d[CoordWidth] ? CoordWidth'(-d) : d[CoordWidth-1:0];
  endfunction

endpackage

[hw/rtl/tafbl_setup.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tafbl_setup
// Four-stage front end: classify against the line, pick the apex, form the
// cross products and the numerator and denominator of the share.
// ----------------------------------------------------------------------------
module tafbl_setup
  import tafbl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  coord_t      line_level_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  tafbl_in_t   in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output tafbl_div_t  out_data_o
);

  localparam int unsigned W = CoordWidth;

  logic rdy_a, rdy_b, rdy_c, rdy_d;
  logic vld_a_q, vld_b_q, vld_c_q, vld_d_q;

  // stage A
  tafbl_in_t in_a_q;

  // stage B
  tafbl_kind_e             kind_b_d, kind_b_q;
  logic                    one_up_b_d, one_up_b_q;
  logic signed [W:0]       ex1_b_d, ey1_b_d, ex2_b_d, ey2_b_d;
  logic signed [W:0]       ex1_b_q, ey1_b_q, ex2_b_q, ey2_b_q;
  logic [W-1:0]            n_b_d, d1_b_d, d2_b_d;
  logic [W-1:0]            n_b_q, d1_b_q, d2_b_q;

  // stage C
  tafbl_kind_e             kind_c_q;
  logic                    one_up_c_q;
  logic signed [2*W+1:0]   p1_c_d, p2_c_d, p1_c_q, p2_c_q;
  logic [ProdWidth-1:0]    nn_c_d, dd_c_d, nn_c_q, dd_c_q;

  // stage D
  tafbl_div_t              out_d_d, out_d_q;

  assign rdy_d      = ~vld_d_q | out_ready_i;
  assign rdy_c      = ~vld_c_q | rdy_d;
  assign rdy_b      = ~vld_b_q | rdy_c;
  assign rdy_a      = ~vld_a_q | rdy_b;
  assign in_ready_o = rdy_a;

  always_comb begin
    coord_t     ys [3];
    logic [2:0] up, ge, le;
    logic [1:0] apex, leg1, leg2;
    coord_t     ay;
    ys[0] = in_a_q.vertex_a_y;
    ys[1] = in_a_q.vertex_b_y;
    ys[2] = in_a_q.vertex_c_y;
    for (int i = 0; i < 3; i++) begin
      up[i] = ys[i] >  line_level_i;
      ge[i] = ys[i] >= line_level_i;
      le[i] = ys[i] <= line_level_i;
    end
    if (&ge) begin
      kind_b_d = KIND_EMPTY;
    end else if (&le) begin
      kind_b_d = KIND_FULL;
    end else begin
      kind_b_d = KIND_CUT;
    end
    one_up_b_d = (up == 3'b001) | (up == 3'b010) | (up == 3'b100);
    if (one_up_b_d) begin
      apex = up[2] ? 2'd2 : (up[1] ? 2'd1 : 2'd0);
    end else begin
      apex = !up[2] ? 2'd2 : (!up[1] ? 2'd1 : 2'd0);
    end
    unique case (apex)
      2'd0:    begin leg1 = 2'd1; leg2 = 2'd2; end
      2'd1:    begin leg1 = 2'd2; leg2 = 2'd0; end
      default: begin leg1 = 2'd0; leg2 = 2'd1; end
    endcase
    ay     = ys[apex];
    n_b_d  = diff_mag(line_level_i, ay);
    d1_b_d = diff_mag(ys[leg1], ay);
    d2_b_d = diff_mag(ys[leg2], ay);
    ex1_b_d = $signed({in_a_q.vertex_b_x[W-1], in_a_q.vertex_b_x})
            - $signed({in_a_q.vertex_a_x[W-1], in_a_q.vertex_a_x});
    ey1_b_d = $signed({in_a_q.vertex_b_y[W-1], in_a_q.vertex_b_y})
            - $signed({in_a_q.vertex_a_y[W-1], in_a_q.vertex_a_y});
    ex2_b_d = $signed({in_a_q.vertex_c_x[W-1], in_a_q.vertex_c_x})
            - $signed({in_a_q.vertex_a_x[W-1], in_a_q.vertex_a_x});
    ey2_b_d = $signed({in_a_q.vertex_c_y[W-1], in_a_q.vertex_c_y})
            - $signed({in_a_q.vertex_a_y[W-1], in_a_q.vertex_a_y});
  end

  assign p1_c_d = ex1_b_q * ey2_b_q;
  assign p2_c_d = ey1_b_q * ex2_b_q;
  assign nn_c_d = ProdWidth'(n_b_q) * ProdWidth'(n_b_q);
  assign dd_c_d = ProdWidth'(d1_b_q) * ProdWidth'(d2_b_q);

  always_comb begin
    out_d_d.kind = kind_c_q;
    if ((kind_c_q == KIND_CUT) && (p1_c_q == p2_c_q)) begin
      out_d_d.kind = KIND_BAD;
    end
    out_d_d.num = one_up_c_q ? (dd_c_q - nn_c_q) : nn_c_q;
    out_d_d.den = dd_c_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
      vld_d_q <= 1'b0;
    end else begin
      if (rdy_a) vld_a_q <= in_valid_i;
      if (rdy_b) vld_b_q <= vld_a_q;
      if (rdy_c) vld_c_q <= vld_b_q;
      if (rdy_d) vld_d_q <= vld_c_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && in_valid_i) begin
      in_a_q <= in_data_i;
    end
    if (rdy_b && vld_a_q) begin
      kind_b_q   <= kind_b_d;
      one_up_b_q <= one_up_b_d;
      ex1_b_q    <= ex1_b_d;
      ey1_b_q    <= ey1_b_d;
      ex2_b_q    <= ex2_b_d;
      ey2_b_q    <= ey2_b_d;
      n_b_q      <= n_b_d;
      d1_b_q     <= d1_b_d;
      d2_b_q     <= d2_b_d;
    end
    if (rdy_c && vld_b_q) begin
      kind_c_q   <= kind_b_q;
      one_up_c_q <= one_up_b_q;
      p1_c_q     <= p1_c_d;
      p2_c_q     <= p2_c_d;
      nn_c_q     <= nn_c_d;
      dd_c_q     <= dd_c_d;
    end
    if (rdy_d && vld_c_q) begin
      out_d_q <= out_d_d;
    end
  end

  assign out_valid_o = vld_d_q;
  assign out_data_o  = out_d_q;

endmodule

[hw/rtl/tafbl_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tafbl_div
// Pipelined restoring divider, one quotient bit per stage, with round to
// nearest and the final share selection in the output register.
// ----------------------------------------------------------------------------
module tafbl_div
  import tafbl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  tafbl_div_t  in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output tafbl_out_t  out_data_o
);

  localparam int unsigned NS = FracBits + 1;
  localparam int unsigned P  = ProdWidth;

  logic [NS-1:0]      vld_q;
  logic [NS:0]        rdy;
  logic [P:0]         rem_q  [NS];
  logic [P-1:0]       den_q  [NS];
  logic [FracBits:0]  quo_q  [NS];
  tafbl_kind_e        kind_q [NS];

  logic               out_vld_q;
  tafbl_out_t         out_q, out_d;
  logic               round_up;

  assign rdy[NS]    = ~out_vld_q | ~out_stall_i;
  assign in_ready_o = rdy[0];

  for (genvar j = 0; j < NS; j++) begin : g_stage
    logic               src_vld;
    logic [P:0]         src_rem;
    logic [P-1:0]       src_den;
    logic [FracBits:0]  src_quo;
    tafbl_kind_e        src_kind;
    logic [P:0]         trial;
    logic               fits;

    if (j == 0) begin : g_head
      assign src_vld  = in_valid_i;
      assign src_rem  = {1'b0, in_data_i.num};
      assign src_den  = in_data_i.den;
      assign src_quo  = '0;
      assign src_kind = in_data_i.kind;
      assign trial    = src_rem;
    end else begin : g_body
      assign src_vld  = vld_q[j-1];
      assign src_rem  = rem_q[j-1];
      assign src_den  = den_q[j-1];
      assign src_quo  = quo_q[j-1];
      assign src_kind = kind_q[j-1];
      assign trial    = {src_rem[P-1:0], 1'b0};
    end

    assign rdy[j] = ~vld_q[j] | rdy[j+1];
    assign fits   = trial >= {1'b0, src_den};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (rdy[j]) begin
        vld_q[j] <= src_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[j] && src_vld) begin
        rem_q[j]  <= fits ? (trial - {1'b0, src_den}) : trial;
        den_q[j]  <= src_den;
        quo_q[j]  <= {src_quo[FracBits-1:0], fits};
        kind_q[j] <= src_kind;
      end
    end
  end

  assign round_up = {rem_q[NS-1][P-1:0], 1'b0} >= {1'b0, den_q[NS-1]};

  always_comb begin
    out_d.bad_triangle = 1'b0;
    unique case (kind_q[NS-1])
      KIND_EMPTY: out_d.covered_fraction = '0;
      KIND_FULL:  out_d.covered_fraction = (FracBits+1)'(1) << FracBits;
      KIND_BAD: begin
        out_d.covered_fraction = '0;
        out_d.bad_triangle     = 1'b1;
      end
      default:    out_d.covered_fraction = quo_q[NS-1] + (FracBits+1)'(round_up);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (rdy[NS]) begin
      out_vld_q <= vld_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[NS] && vld_q[NS-1]) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.bad_triangle |-> out_q.covered_fraction == '0)
    else $error("flagged triangle carries a nonzero share");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> out_q.covered_fraction <= ((FracBits+1)'(1) << FracBits))
    else $error("share above one");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NS-1] && !rdy[NS] |=> vld_q[NS-1] && $stable(quo_q[NS-1]))
    else $error("last divider stage lost its beat under stall");

endmodule

[hw/rtl/triangle_area_fraction_below_line.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_area_fraction_below_line
// Share of a triangle's area below a horizontal line, Q1.16.
//
//   channel  dir  handshake            beat
//   in       in   in_valid_i/stall_o   tafbl_in_t (three vertices)
//   out      out  out_valid_o/stall_i  tafbl_out_t (share, flag)
//   cfg      in   cfg_valid_i/ready_o  line level, Q16.16
//
// One triangle per cycle sustained while out_stall_i is low. The path runs
// through four front-end stages, one divider stage per quotient bit and one
// output register. Per-stage valid bits let bubbles close up under a stall.
// Reset clears all valid bits and sets the line level to zero.
// ----------------------------------------------------------------------------
module triangle_area_fraction_below_line
  import tafbl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  tafbl_in_t   in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output tafbl_out_t  out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  coord_t      cfg_data_i
);

  coord_t     line_level_q;
  logic       setup_ready;
  logic       mid_valid, mid_ready;
  tafbl_div_t mid_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_level_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      line_level_q <= cfg_data_i;
    end
  end

  tafbl_setup u_setup (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .line_level_i (line_level_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (setup_ready),
    .in_data_i    (in_data_i),
    .out_valid_o  (mid_valid),
    .out_ready_i  (mid_ready),
    .out_data_o   (mid_data)
  );

  tafbl_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mid_valid),
    .in_ready_o  (mid_ready),
    .in_data_i   (mid_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  assign in_stall_o = ~setup_ready;

endmodule

[test/tb_triangle_area_fraction_below_line.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_triangle_area_fraction_below_line
// Self-checking bench for the triangle area share block.
//
// A queue-fed driver offers triangle beats and a monitor predicts the share
// below the line level for each accepted beat. Each result beat is checked
// field by field in order. Phases vary the line level, including both
// extremes, and the sender and receiver idle patterns. One long receiver
// hold-off fills the pipeline so that the input stalls.
// ----------------------------------------------------------------------------
module tb_triangle_area_fraction_below_line;
  import tafbl_pkg::*;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  localparam int CycleLimit = 500000;
  localparam int DrainCycles = 30;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  tafbl_in_t  in_data_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  tafbl_out_t out_data_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  coord_t     cfg_data_i = '0;

  tafbl_in_t  triangle_q[$];
  tafbl_out_t share_expected_q[$];
  coord_t     level_model = '0;
  idle_mode_e idle_mode = IDLE_NONE;
  int         errors = 0;
  int         cycles = 0;
  int         hold_left = 0;
  logic       hold_start = 1'b0;

  triangle_area_fraction_below_line uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic tafbl_out_t area_share_below(tafbl_in_t v, coord_t level);
    longint py[3];
    longint lv, lo, hi;
    logic signed [69:0] ex1, ey1, ex2, ey2;
    logic [99:0] num, den, q;
    int ups, apex_up, apex_dn, apex, leg1, leg2;
    tafbl_out_t r;
    py[0] = v.vertex_a_y;
    py[1] = v.vertex_b_y;
    py[2] = v.vertex_c_y;
    lv = level;
    lo = py[0];
    hi = py[0];
    for (int i = 1; i < 3; i++) begin
      if (py[i] < lo) lo = py[i];
      if (py[i] > hi) hi = py[i];
    end
    r = '0;
    if (lo >= lv) begin
      r.covered_fraction = '0;
    end else if (hi <= lv) begin
      r.covered_fraction = (FracBits+1)'(1) << FracBits;
    end else begin
      ex1 = longint'(v.vertex_b_x) - longint'(v.vertex_a_x);
      ey1 = py[1] - py[0];
      ex2 = longint'(v.vertex_c_x) - longint'(v.vertex_a_x);
      ey2 = py[2] - py[0];
      if (ex1 * ey2 == ey1 * ex2) begin
        r.bad_triangle = 1'b1;
      end else begin
        ups = 0;
        apex_up = 0;
        apex_dn = 0;
        for (int i = 0; i < 3; i++) begin
          if (py[i] > lv) begin
            ups++;
            apex_up = i;
          end else begin
            apex_dn = i;
          end
        end
        apex = (ups == 1) ? apex_up : apex_dn;
        leg1 = (apex + 1) % 3;
        leg2 = (apex + 2) % 3;
        num = 100'(lv > py[apex] ? lv - py[apex] : py[apex] - lv);
        num = num * num;
        den = 100'(py[leg1] > py[apex] ? py[leg1] - py[apex] : py[apex] - py[leg1]) *
              100'(py[leg2] > py[apex] ? py[leg2] - py[apex] : py[apex] - py[leg2]);
        if (ups == 1) num = den - num;
        q = ((num << (FracBits + 1)) + den) / (den << 1);
        r.covered_fraction = q[FracBits:0];
      end
    end
    return r;
  endfunction

  // input side: accept at posedge, drive at negedge
  logic in_taken = 1'b0;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
    in_taken = in_valid_i && !in_stall_o;
    if (in_taken) share_expected_q.push_back(area_share_below(in_data_i, level_model));
    if (out_valid_o && !out_stall_i) begin
      if (share_expected_q.size() == 0) begin
        $error("unexpected result beat: covered_fraction %0d bad_triangle %0d",
               out_data_o.covered_fraction, out_data_o.bad_triangle);
        errors++;
      end else begin
        tafbl_out_t want;
        want = share_expected_q.pop_front();
        if (out_data_o.covered_fraction !== want.covered_fraction) begin
          $error("covered_fraction: expected %0d, got %0d",
                 want.covered_fraction, out_data_o.covered_fraction);
          errors++;
        end
        if (out_data_o.bad_triangle !== want.bad_triangle) begin
          $error("bad_triangle: expected %0d, got %0d",
                 want.bad_triangle, out_data_o.bad_triangle);
          errors++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      if (triangle_q.size() != 0 &&
          !((idle_mode == IDLE_SEND && $urandom_range(99) < 78) ||
            (idle_mode == IDLE_BOTH && $urandom_range(99) < 32))) begin
        in_data_i  <= triangle_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_start) hold_left <= 300;
    else if (hold_left > 0) hold_left <= hold_left - 1;
  end

  always @(negedge clk_i) begin
    out_stall_i <= (hold_left > 0) ||
                   (idle_mode == IDLE_RECV && $urandom_range(99) < 78) ||
                   (idle_mode == IDLE_BOTH && $urandom_range(99) < 32);
  end

  task automatic add_triangle(longint ax, longint ay, longint bx, longint by,
                              longint cx, longint cy);
    tafbl_in_t t;
    t.vertex_a_x = coord_t'(ax);
    t.vertex_a_y = coord_t'(ay);
    t.vertex_b_x = coord_t'(bx);
    t.vertex_b_y = coord_t'(by);
    t.vertex_c_x = coord_t'(cx);
    t.vertex_c_y = coord_t'(cy);
    triangle_q.push_back(t);
  endtask

  function automatic longint near_level(longint level);
    longint off, v;
    off = longint'($urandom()) & ((64'd1 << $urandom_range(31)) - 1);
    v = $urandom_range(1) ? level + off : level - off;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v;
  endfunction

  function automatic longint any_coord();
    return longint'(signed'($urandom()));
  endfunction

  task automatic add_random_triangles(int n);
    longint ax, ay, dx, dy;
    int kind;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(9);
      if (kind < 6) begin
        add_triangle(any_coord(), near_level(level_model), any_coord(),
                     near_level(level_model), any_coord(), near_level(level_model));
      end else if (kind < 8) begin
        ax = longint'(signed'($urandom())) >>> 4;
        ay = near_level(level_model) >>> 2;
        dx = longint'(int'($urandom_range(2000000))) - 1000000;
        dy = longint'(int'($urandom_range(2000000))) - 1000000;
        add_triangle(ax, ay, ax + dx, ay + dy, ax + 2 * dx, ay + 2 * dy);
      end else begin
        add_triangle(any_coord(), any_coord(), any_coord(), any_coord(),
                     any_coord(), any_coord());
      end
    end
  endtask

  task automatic write_level(coord_t level);
    repeat (DrainCycles) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= level;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    level_model = level;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (triangle_q.size() != 0 || in_valid_i || share_expected_q.size() != 0)
      @(posedge clk_i);
  endtask

  initial begin
    coord_t levels[7];
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset level of zero
    add_triangle(0, 0, 100, 0, 50, 0);
    add_triangle(-2147483648, -2147483648, 2147483647, -2147483648, 0, -2147483648);
    add_triangle(2147483647, 2147483647, -2147483648, 2147483647, 0, 2147483647);
    add_triangle(0, -2147483648, 1, 2147483647, -2147483648, 2147483647);
    add_triangle(-2147483648, 2147483647, 2147483647, -2147483648, 0, -2147483648);
    add_triangle(0, 65536, -65536, -65536, 65536, -65536);
    add_triangle(0, -65536, -65536, 65536, 65536, 65536);
    add_triangle(-65536, 65536, 0, -65536, 65536, 65536);
    add_triangle(0, -65536, 0, 0, 0, 65536);
    add_triangle(-65536, -65536, 0, 0, 65536, 65536);
    add_triangle(-2147483648, -2147483648, 0, 0, 2147483646, 2147483646);
    add_triangle(0, 0, 65536, 0, 0, -65536);
    add_triangle(0, 0, 65536, 0, 0, 65536);
    add_triangle(0, 1, 3, -2, -3, -2);
    add_triangle(0, -1, 3, 2, -3, 2);
    add_triangle(5, 3, 7, -1, 9, 3);
    add_triangle(2147483647, 2147483647, -2147483648, -2147483648, 2147483647,
                 -2147483648);
    add_triangle(-1, -1, 1, 1, 1, -1);
    wait_drained();

    levels = '{32'sh0001_8000, -32'sd2147483648, 32'sd2147483647, -32'sh0000_4000,
               32'sh1234_5678, -32'sh7000_0000, 32'sh0000_0001};
    for (int p = 0; p < 7; p++) begin
      write_level(levels[p]);
      idle_mode = idle_mode_e'(p % 4);
      if (p == 4) begin
        idle_mode = IDLE_NONE;
        @(negedge clk_i);
        hold_start <= 1'b1;
        @(negedge clk_i);
        hold_start <= 1'b0;
      end
      add_random_triangles(150);
      wait_drained();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0 && share_expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/tafbl_pkg.sv
hw/rtl/tafbl_setup.sv
hw/rtl/tafbl_div.sv
hw/rtl/triangle_area_fraction_below_line.sv
test/tb_triangle_area_fraction_below_line.sv
